@@ sv/cst_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the call stack trie interner.
// No dependencies; imported by every module of the block.
package cst_pkg;

  // Default sizes
  localparam int DEF_NODES      = 4096;
  localparam int DEF_EDGE_SLOTS = 8192;
  localparam int DEF_MAX_DEPTH  = 64;

  // Fixed field widths
  localparam int FRAME_W  = 64;
  localparam int QID_W    = 12;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 13;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  // Hash multipliers
  localparam logic [63:0] HASH_GOLD = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HASH_MIX  = 64'hBF58476D1CE4E5B9;

endpackage

@@ sv/cst_ram.sv @@
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM with registered read.
// Depends on cst_pkg only for the house import.
module cst_ram
  import cst_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/cst_hash.sv @@
`timescale 1ns / 1ps
// Four-stage pipelined slot hash of (parent node, frame address).
// Depends on cst_pkg for the hash multipliers.
module cst_hash
  import cst_pkg::*;
#(
  parameter int ID_W  = 12,
  parameter int IDX_W = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [ID_W-1:0]    parent,
  input  logic [FRAME_W-1:0] frame,
  output logic               done,
  output logic [IDX_W-1:0]   idx
);

  logic [3:0]         vld;
  logic [FRAME_W-1:0] frame1;
  logic [ID_W+31:0]   gp_lo;
  logic [31:0]        gp_hi;
  logic [63:0]        h1;
  logic [63:0]        ll;
  logic [31:0]        hl;
  logic [31:0]        lh;
  logic [63:0]        gp_sum;
  logic [63:0]        h1_next;
  logic [63:0]        h3;
  logic [ID_W+31:0]   gp_lo_next;
  logic [63:0]        ll_next;

  // Stage valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], start};
    end
  end

  assign done = vld[3];

  // Products and mixing steps
  always_comb begin
    gp_lo_next = parent * HASH_GOLD[31:0];
    gp_sum     = 64'(gp_lo) + {gp_hi, 32'b0};
    h1_next    = frame1 ^ gp_sum;
    h1_next    = h1_next ^ (h1_next >> 31);
    ll_next    = h1[31:0] * HASH_MIX[31:0];
    h3         = ll + {hl + lh, 32'b0};
    h3         = h3 ^ (h3 >> 29);
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    gp_lo  <= gp_lo_next;
    gp_hi  <= 32'(parent * HASH_GOLD[63:32]);
    frame1 <= frame;
    h1     <= h1_next;
    ll     <= ll_next;
    hl     <= 32'(h1[63:32] * HASH_MIX[31:0]);
    lh     <= 32'(h1[31:0] * HASH_MIX[63:32]);
    idx    <= h3[IDX_W-1:0];
  end

endmodule

@@ sv/call_stack_trie_interner_top.sv @@
`timescale 1ns / 1ps
// Call stack prefix trie: the interning sequencer around the edge and node RAMs.
// Depends on cst_pkg, cst_ram and cst_hash.

// Interns call stacks one frame per insert transaction, outermost frame first;
// the transaction with end_of_trace set returns the leaf id of the trace. A
// query transaction returns the frames of a stored trace innermost first, or
// one not_found result. One transaction is processed at a time. An insert
// frame passes through the hash pipeline, then probes the edge RAM (linear
// probing, one read per probe; a read state and a check state per probe) and
// ends in a closing state; a trace end adds the leaf read-modify-write of the
// node RAM and the result. A frame that is skipped (failed trace or past the
// depth limit) goes straight to the closing state. A query reads the node RAM
// and checks each returned frame along the parent chain. After reset the block
// clears the edge RAM with in_stall high. EDGE_SLOTS must be a power of two.
module call_stack_trie_interner_top
  import cst_pkg::*;
#(
  parameter int NODES      = DEF_NODES,
  parameter int EDGE_SLOTS = DEF_EDGE_SLOTS,
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [FRAME_W-1:0]  frame_addr,
  input  logic                end_of_trace,
  input  logic [QID_W-1:0]    query_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [QID_W-1:0]    trace_id,
  output logic [FRAME_W-1:0]  out_frame,
  output logic                last,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  trace_count
);

  localparam int ID_W  = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);
  localparam int IDX_W = $clog2(EDGE_SLOTS);
  localparam int PRB_W = $clog2(EDGE_SLOTS + 1);
  localparam int DEP_W = $clog2(MAX_DEPTH + 1);
  localparam int K_W   = $clog2(MAX_DEPTH);
  localparam int EW    = 1 + 2 * ID_W + FRAME_W;
  localparam int NW    = FRAME_W + ID_W + 1;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_HASH  = 4'd2;
  localparam logic [3:0] ST_PROBE = 4'd3;
  localparam logic [3:0] ST_PCHK  = 4'd4;
  localparam logic [3:0] ST_EOT   = 4'd5;
  localparam logic [3:0] ST_LEAF  = 4'd6;
  localparam logic [3:0] ST_RES   = 4'd7;
  localparam logic [3:0] ST_QRD   = 4'd8;
  localparam logic [3:0] ST_QCHK  = 4'd9;

  logic [3:0]          state;
  logic [IDX_W-1:0]    clr_addr;
  logic [ID_W-1:0]     cursor;
  logic [CNT_W-1:0]    node_count;
  logic [CNT_W-1:0]    leaf_count;
  logic [DEP_W-1:0]    depth;
  logic                failed;
  logic [IDX_W-1:0]    idx;
  logic [PRB_W-1:0]    probe_cnt;
  logic [FRAME_W-1:0]  frame_q;
  logic                eot_q;
  logic [QID_W-1:0]    qid_q;
  logic [ID_W-1:0]     walk_node;
  logic [K_W-1:0]      k;
  logic [QID_W-1:0]    res_id;
  logic [STATUS_W-1:0] res_status;

  logic                out_free;
  logic                out_load;
  logic                hash_start;
  logic                hash_done;
  logic [IDX_W-1:0]    hash_idx;

  logic                e_we;
  logic [IDX_W-1:0]    e_waddr;
  logic [EW-1:0]       e_wdata;
  logic [EW-1:0]       e_rdata;
  logic                n_we;
  logic [ID_W-1:0]     n_waddr;
  logic [NW-1:0]       n_wdata;
  logic                n_re;
  logic [ID_W-1:0]     n_raddr;
  logic [NW-1:0]       n_rdata;

  logic                e_valid;
  logic [ID_W-1:0]     e_parent;
  logic [ID_W-1:0]     e_child;
  logic [FRAME_W-1:0]  e_frame;
  logic                e_hit;
  logic                create;
  logic [FRAME_W-1:0]  n_frame;
  logic [ID_W-1:0]     n_parent;
  logic                n_leaf;
  logic                q_last;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Unpack RAM words
  assign e_valid  = e_rdata[EW-1];
  assign e_parent = e_rdata[EW-2 -: ID_W];
  assign e_child  = e_rdata[FRAME_W+ID_W-1 -: ID_W];
  assign e_frame  = e_rdata[FRAME_W-1:0];
  assign e_hit    = e_valid && (e_frame == frame_q) && (e_parent == cursor);
  assign create   = (state == ST_PCHK) && !e_valid && (node_count < CNT_W'(NODES));

  assign n_frame  = n_rdata[NW-1 -: FRAME_W];
  assign n_parent = n_rdata[ID_W:1];
  assign n_leaf   = n_rdata[0];
  assign q_last   = (n_parent == '0) || (k == K_W'(MAX_DEPTH - 1));

  assign hash_start = in_valid && !in_stall && (command == CMD_INSERT) &&
                      !failed && (depth < DEP_W'(MAX_DEPTH));

  // Load the output register with a result transaction
  assign out_load = ((state == ST_RES) ||
                     (state == ST_QCHK && !(k == '0 && !n_leaf))) && out_free;

  // RAM port control
  always_comb begin
    e_we    = 1'b0;
    e_waddr = idx;
    e_wdata = {1'b1, cursor, node_count[ID_W-1:0], frame_q};
    if (state == ST_CLEAR) begin
      e_we    = 1'b1;
      e_waddr = clr_addr;
      e_wdata = '0;
    end else if (create) begin
      e_we = 1'b1;
    end

    n_we    = 1'b0;
    n_waddr = node_count[ID_W-1:0];
    n_wdata = {frame_q, cursor, 1'b0};
    if (create) begin
      n_we = 1'b1;
    end else if (state == ST_LEAF && !n_leaf) begin
      n_we    = 1'b1;
      n_waddr = cursor;
      n_wdata = {n_rdata[NW-1:1], 1'b1};
    end

    n_re    = (state == ST_EOT && eot_q && !failed) || (state == ST_QRD);
    n_raddr = (state == ST_QRD) ? walk_node : cursor;
  end

  cst_hash #(
    .ID_W  (ID_W),
    .IDX_W (IDX_W)
  ) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .parent (cursor),
    .frame  (frame_addr),
    .done   (hash_done),
    .idx    (hash_idx)
  );

  cst_ram #(
    .WIDTH (EW),
    .DEPTH (EDGE_SLOTS)
  ) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (state == ST_PROBE),
    .raddr (idx),
    .rdata (e_rdata)
  );

  cst_ram #(
    .WIDTH (NW),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .re    (n_re),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  // Output valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      cursor     <= '0;
      node_count <= CNT_W'(1);
      leaf_count <= '0;
      depth      <= '0;
      failed     <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(EDGE_SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            frame_q <= frame_addr;
            eot_q   <= end_of_trace;
            qid_q   <= query_id;
            if (command == CMD_QUERY) begin
              if (query_id == '0 || 32'(query_id) >= 32'(node_count)) begin
                res_id     <= query_id;
                res_status <= STATUS_NOT_FOUND;
                state      <= ST_RES;
              end else begin
                walk_node <= ID_W'(query_id);
                k         <= '0;
                state     <= ST_QRD;
              end
            end else if (hash_start) begin
              state <= ST_HASH;
            end else begin
              state <= ST_EOT;
            end
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            idx       <= hash_idx;
            probe_cnt <= '0;
            state     <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          state <= ST_PCHK;
        end
        ST_PCHK: begin
          if (!e_valid) begin
            if (create) begin
              cursor     <= node_count[ID_W-1:0];
              node_count <= node_count + 1'b1;
              depth      <= depth + 1'b1;
            end else begin
              failed <= 1'b1;
            end
            state <= ST_EOT;
          end else if (e_hit) begin
            cursor <= e_child;
            depth  <= depth + 1'b1;
            state  <= ST_EOT;
          end else if (probe_cnt == PRB_W'(EDGE_SLOTS - 1)) begin
            failed <= 1'b1;
            state  <= ST_EOT;
          end else begin
            idx       <= idx + 1'b1;
            probe_cnt <= probe_cnt + 1'b1;
            state     <= ST_PROBE;
          end
        end
        ST_EOT: begin
          if (!eot_q) begin
            state <= ST_IDLE;
          end else if (failed) begin
            res_id     <= '0;
            res_status <= STATUS_FULL;
            state      <= ST_RES;
          end else begin
            state <= ST_LEAF;
          end
        end
        ST_LEAF: begin
          if (!n_leaf) begin
            leaf_count <= leaf_count + 1'b1;
          end
          res_id     <= QID_W'(cursor);
          res_status <= STATUS_OK;
          state      <= ST_RES;
        end
        ST_RES: begin
          if (out_free) begin
            trace_id    <= res_id;
            out_frame   <= '0;
            last        <= 1'b1;
            status      <= res_status;
            trace_count <= COUNT_W'(leaf_count);
            if (res_status != STATUS_NOT_FOUND) begin
              cursor <= '0;
              depth  <= '0;
              failed <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        ST_QRD: begin
          state <= ST_QCHK;
        end
        ST_QCHK: begin
          if (k == '0 && !n_leaf) begin
            res_id     <= qid_q;
            res_status <= STATUS_NOT_FOUND;
            state      <= ST_RES;
          end else if (out_free) begin
            trace_id    <= qid_q;
            out_frame   <= n_frame;
            last        <= q_last;
            status      <= STATUS_OK;
            trace_count <= COUNT_W'(leaf_count);
            walk_node   <= n_parent;
            k           <= k + 1'b1;
            state       <= q_last ? ST_IDLE : ST_QRD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !out_valid)
    else $error("result issued during edge RAM clear");
  a_create_count: assert property (@(posedge clk) disable iff (rst)
    create |=> node_count == $past(node_count) + 1'b1)
    else $error("node count did not advance on node creation");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEP_W'(MAX_DEPTH))
    else $error("trace depth beyond limit");
  a_leaf_bound: assert property (@(posedge clk) disable iff (rst)
    leaf_count < node_count)
    else $error("more leaves than non-root nodes");
`endif

endmodule
